// ----- rtl/arsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the adaptive replacement set policy.
// Used by the channel interfaces, the step divider and the top level.
// Depends on nothing.
package arsp_pkg;

	// Fixed widths of the item fields on the channels.
	localparam int OPC_W    = 2;
	localparam int SET_IN_W = 6;
	localparam int WAY_IN_W = 3;
	localparam int TAG_IN_W = 32;
	localparam int VWAY_W   = 3;
	localparam int GHIT_W   = 2;
	localparam int TS_W     = 5;

	// Width of the access counter and of the per-line use stamps.
	localparam int STAMP_W = 32;

	// Operation codes of an input item.
	typedef enum logic [OPC_W-1:0] {
		OP_INSERT = 2'd0,
		OP_TOUCH  = 2'd1,
		OP_INVAL  = 2'd2,
		OP_VICTIM = 2'd3
	} opcode_t;

	// Ghost hit codes of an insert result.
	typedef enum logic [GHIT_W-1:0] {
		GH_NONE = 2'd0,
		GH_B1   = 2'd1,
		GH_B2   = 2'd2
	} ghit_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_ROW,
		ST_GS_RD,
		ST_GS_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_DIV,
		ST_DIV_WAIT,
		ST_PUPD,
		ST_VCNT,
		ST_VSCAN,
		ST_VSEL,
		ST_VTAG_RD,
		ST_VTAG,
		ST_PUSH,
		ST_WB,
		ST_FIN
	} state_t;

	// Status of the step divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/arsp_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request items and result items.
// Depends on arsp_pkg for the field widths.
interface arsp_req_if;
	logic                          valid;
	logic                          ready;
	logic [arsp_pkg::OPC_W-1:0]    opcode;
	logic [arsp_pkg::SET_IN_W-1:0] set_index;
	logic [arsp_pkg::WAY_IN_W-1:0] way_index;
	logic [arsp_pkg::TAG_IN_W-1:0] line_tag;

	modport source(output valid, opcode, set_index, way_index, line_tag, input ready);
	modport sink(input valid, opcode, set_index, way_index, line_tag, output ready);
endinterface

interface arsp_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        victim_found;
	logic [arsp_pkg::VWAY_W-1:0] victim_way;
	logic [arsp_pkg::GHIT_W-1:0] ghost_hit;
	logic [arsp_pkg::TS_W-1:0]   target_size;

	modport source(output valid, victim_found, victim_way, ghost_hit, target_size,
		input ready);
	modport sink(input valid, victim_found, victim_way, ghost_hit, target_size,
		output ready);
endinterface

// ----- rtl/arsp_div.sv -----
`timescale 1ns / 1ps
// Iterative ceiling divider for the adaptive target step, one subtract a cycle.
// Depends on arsp_pkg for the status struct.
module arsp_div #(
	parameter int W = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [W-1:0]        num,
	input  logic [W-1:0]        den,
	output arsp_pkg::div_stat_t stat,
	output logic [W-1:0]        quot
);

	logic         busy_q;
	logic         done_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] den_q;
	logic [W-1:0] quot_q;

	// Control flags of the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
			end else if (busy_q && !(rem_q > den_q)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient: subtract the divisor until what is left fits once.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			if (rem_q > den_q) begin
				rem_q  <= rem_q - den_q;
				quot_q <= quot_q + W'(1);
			end else if (rem_q != '0) begin
				rem_q  <= '0;
				quot_q <= quot_q + W'(1);
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy_q |=> busy_q) else $error("divider did not start");
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q) else $error("divider finished without done");

endmodule

// ----- rtl/adaptive_replacement_set_policy.sv -----
`timescale 1ns / 1ps
// Top level of the adaptive replacement set policy: sequencer, set stores and
// tag memories. Depends on arsp_pkg, arsp_if (channels) and arsp_div.

// After reset the block runs a clearing pass over its per-set rows and
// takes no item meanwhile. It then handles one item at a time; the
// request channel is ready only while the sequencer is idle, and a result may
// still wait in the output register while the next item is taken. An item
// steps through its scans one element at a time on one compare path: an
// insert reads and compares each ghost entry searched (at most 2*WAYS),
// shifts the later entries down after a ghost hit and runs the step divider;
// a victim request counts and scans the ways, then shifts a full ghost list.
// When SETS is below 64 the set index is first reduced by one subtraction
// of SETS a cycle. An item also waits in its final state until the previous
// result has been taken.
module adaptive_replacement_set_policy #(
	parameter int SETS     = 64,
	parameter int WAYS     = 8,
	parameter int TAG_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	arsp_req_if.sink   req,
	arsp_rsp_if.source rsp
);

	localparam int STAMP_W = arsp_pkg::STAMP_W;
	localparam int WAY_W   = $clog2(WAYS);
	localparam int FILL_W  = $clog2(WAYS + 1);
	localparam int P_W     = $clog2(2 * WAYS + 1);
	localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int LINES   = SETS * WAYS;
	localparam int LINE_AW = $clog2(LINES);

	arsp_pkg::state_t state_q, state_d;

	// Control registers.
	logic [SET_W-1:0]   clr_q;
	logic [STAMP_W-1:0] now_q;
	logic               out_valid_q;

	// Item registers.
	arsp_pkg::opcode_t             op_q;
	logic [arsp_pkg::SET_IN_W-1:0] set_raw_q;
	logic [arsp_pkg::WAY_IN_W-1:0] way_q;
	logic [TAG_BITS-1:0]           tag_q;

	// Working copy of the addressed set's row.
	logic [WAYS-1:0]               valid_r;
	logic [WAYS-1:0]               freq_r;
	logic [WAYS-1:0][STAMP_W-1:0]  stamp_r;
	logic [FILL_W-1:0]             f1_r;
	logic [FILL_W-1:0]             f2_r;
	logic [P_W-1:0]                p_r;

	// Row as loaded, with the addressed line already updated.
	logic [WAYS-1:0]               valid_ld;
	logic [WAYS-1:0]               freq_ld;
	logic [WAYS-1:0][STAMP_W-1:0]  stamp_ld;

	// Scan and list walk registers.
	logic [FILL_W-1:0]  idx_q;
	logic [FILL_W-1:0]  n_q;
	logic               list_q;
	logic [FILL_W-1:0]  n1_q;
	logic [FILL_W-1:0]  n2_q;
	logic [STAMP_W-1:0] oldest_q;
	logic [WAY_W-1:0]   best_q;
	logic               have_q;
	logic [WAY_W-1:0]   first_q;
	logic               fhave_q;
	logic               found_q;
	arsp_pkg::ghit_t    hit_q;

	// Result payload registers.
	logic                        res_found_q;
	logic [arsp_pkg::VWAY_W-1:0] res_way_q;
	logic [arsp_pkg::GHIT_W-1:0] res_ghit_q;
	logic [arsp_pkg::TS_W-1:0]   res_ts_q;

	// Row memories, one row per set.
	logic [WAYS-1:0]              valid_mem [SETS];
	logic [WAYS-1:0]              freq_mem  [SETS];
	logic [WAYS-1:0][STAMP_W-1:0] stamp_mem [SETS];
	logic [FILL_W-1:0]            f1_mem    [SETS];
	logic [FILL_W-1:0]            f2_mem    [SETS];
	logic [P_W-1:0]               p_mem     [SETS];
	logic [WAYS-1:0]              valid_rd;
	logic [WAYS-1:0]              freq_rd;
	logic [WAYS-1:0][STAMP_W-1:0] stamp_rd;
	logic [FILL_W-1:0]            f1_rd;
	logic [FILL_W-1:0]            f2_rd;
	logic [P_W-1:0]               p_rd;

	// Line tag and ghost tag memories.
	logic [TAG_BITS-1:0] tag_mem [LINES];
	logic [TAG_BITS-1:0] b1_mem  [LINES];
	logic [TAG_BITS-1:0] b2_mem  [LINES];
	logic [TAG_BITS-1:0] tag_rd;
	logic [TAG_BITS-1:0] b1_rd;
	logic [TAG_BITS-1:0] b2_rd;

	// Decoded item and derived signals.
	logic [SET_W-1:0]    set_w;
	logic [WAY_W-1:0]    way_w;
	logic [WAY_W-1:0]    idx_w;
	logic                way_ok;
	logic                accept;
	logic                out_load;
	logic [TAG_BITS-1:0] gh_rd;
	logic                gs_match;
	logic                idx_more;
	logic                idx_last;
	logic                from_t1;
	logic                scan_take;
	logic [FILL_W-1:0]   vfill;

	// Memory and unit controls.
	logic                row_we;
	logic [SET_W-1:0]    row_addr;
	logic                tag_we;
	logic                b1_we;
	logic                b2_we;
	logic [WAY_W-1:0]    gh_rway;
	logic [WAY_W-1:0]    gh_wway;
	logic [TAG_BITS-1:0] gh_wdata;
	logic                div_start;

	// Step divider signals.
	arsp_pkg::div_stat_t div_stat;
	logic [FILL_W-1:0]   div_num;
	logic [FILL_W-1:0]   div_den;
	logic [FILL_W-1:0]   div_quot;
	logic [FILL_W-1:0]   delta;
	logic [P_W:0]        p_sum;
	logic [P_W:0]        p_cap;

	// Line address of a way within the current set.
	function automatic logic [LINE_AW-1:0] line_addr(input logic [SET_W-1:0] s,
		input logic [WAY_W-1:0] w);
		line_addr = LINE_AW'(s) * LINE_AW'(WAYS) + LINE_AW'(w);
	endfunction

	// Decoding and compares of the shared scan path.
	always_comb begin
		set_w     = SET_W'(set_raw_q);
		way_w     = WAY_W'(way_q);
		idx_w     = WAY_W'(idx_q);
		way_ok    = int'(way_q) < WAYS;
		accept    = req.valid && req.ready;
		gh_rd     = list_q ? b2_rd : b1_rd;
		gs_match  = gh_rd == tag_q;
		idx_more  = int'(idx_q) + 1 < int'(n_q);
		idx_last  = idx_q == FILL_W'(WAYS - 1);
		from_t1   = (int'(n1_q) > int'(p_r)) || (n2_q == '0);
		scan_take = valid_r[idx_w] && (freq_r[idx_w] != from_t1)
			&& (stamp_r[idx_w] < oldest_q);
		vfill     = freq_r[best_q] ? f2_r : f1_r;
		div_num   = list_q ? f1_r : f2_r;
		div_den   = list_q ? f2_r : f1_r;
		delta     = (div_den >= div_num) ? FILL_W'(1) : div_quot;
		p_sum     = (P_W + 1)'(p_r) + (P_W + 1)'(delta);
		p_cap     = (P_W + 1)'(f1_r) + (P_W + 1)'(f2_r);
	end

	// Line update of insert, touch and invalidate applied to the row as it is read.
	always_comb begin
		valid_ld = valid_rd;
		freq_ld  = freq_rd;
		stamp_ld = stamp_rd;
		if (way_ok) begin
			unique case (op_q)
				arsp_pkg::OP_INSERT: begin
					stamp_ld[way_w] = now_q;
					valid_ld[way_w] = 1'b1;
					freq_ld[way_w]  = 1'b0;
				end
				arsp_pkg::OP_TOUCH: begin
					stamp_ld[way_w] = now_q;
					freq_ld[way_w]  = 1'b1;
				end
				arsp_pkg::OP_INVAL:  valid_ld[way_w] = 1'b0;
				arsp_pkg::OP_VICTIM: ;
				default: ;
			endcase
		end
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			arsp_pkg::ST_CLEAR: begin
				if (clr_q == SET_W'(SETS - 1)) state_d = arsp_pkg::ST_IDLE;
			end
			arsp_pkg::ST_IDLE: begin
				if (req.valid) state_d = arsp_pkg::ST_MOD;
			end
			arsp_pkg::ST_MOD: begin
				if (int'(set_raw_q) < SETS) state_d = arsp_pkg::ST_ROW;
			end
			arsp_pkg::ST_ROW: begin
				if (op_q == arsp_pkg::OP_VICTIM) begin
					state_d = arsp_pkg::ST_VCNT;
				end else if (!way_ok) begin
					state_d = arsp_pkg::ST_FIN;
				end else if (op_q == arsp_pkg::OP_INSERT
					&& (f1_rd != '0 || f2_rd != '0)) begin
					state_d = arsp_pkg::ST_GS_RD;
				end else begin
					state_d = arsp_pkg::ST_WB;
				end
			end
			arsp_pkg::ST_GS_RD: state_d = arsp_pkg::ST_GS_CMP;
			arsp_pkg::ST_GS_CMP: begin
				if (gs_match) begin
					state_d = idx_more ? arsp_pkg::ST_SH_RD : arsp_pkg::ST_DIV;
				end else if (idx_more || (!list_q && f2_r != '0)) begin
					state_d = arsp_pkg::ST_GS_RD;
				end else begin
					state_d = arsp_pkg::ST_WB;
				end
			end
			arsp_pkg::ST_SH_RD: state_d = arsp_pkg::ST_SH_WR;
			arsp_pkg::ST_SH_WR: begin
				if (int'(idx_q) + 2 < int'(n_q)) begin
					state_d = arsp_pkg::ST_SH_RD;
				end else if (op_q == arsp_pkg::OP_VICTIM) begin
					state_d = arsp_pkg::ST_PUSH;
				end else begin
					state_d = arsp_pkg::ST_DIV;
				end
			end
			arsp_pkg::ST_DIV:      state_d = arsp_pkg::ST_DIV_WAIT;
			arsp_pkg::ST_DIV_WAIT: begin
				if (div_stat.done) state_d = arsp_pkg::ST_PUPD;
			end
			arsp_pkg::ST_PUPD: state_d = arsp_pkg::ST_WB;
			arsp_pkg::ST_VCNT: begin
				if (idx_last) state_d = arsp_pkg::ST_VSCAN;
			end
			arsp_pkg::ST_VSCAN: begin
				if (idx_last) state_d = arsp_pkg::ST_VSEL;
			end
			arsp_pkg::ST_VSEL: begin
				state_d = (have_q || fhave_q) ? arsp_pkg::ST_VTAG_RD : arsp_pkg::ST_FIN;
			end
			arsp_pkg::ST_VTAG_RD: state_d = arsp_pkg::ST_VTAG;
			arsp_pkg::ST_VTAG: begin
				state_d = (int'(vfill) >= WAYS) ? arsp_pkg::ST_SH_RD : arsp_pkg::ST_PUSH;
			end
			arsp_pkg::ST_PUSH: state_d = arsp_pkg::ST_WB;
			arsp_pkg::ST_WB:   state_d = arsp_pkg::ST_FIN;
			arsp_pkg::ST_FIN: begin
				if (!out_valid_q || rsp.ready) state_d = arsp_pkg::ST_IDLE;
			end
			default: state_d = arsp_pkg::ST_CLEAR;
		endcase
	end

	// Memory, divider and handshake controls decoded from the state.
	always_comb begin
		row_we    = (state_q == arsp_pkg::ST_CLEAR) || (state_q == arsp_pkg::ST_WB);
		row_addr  = (state_q == arsp_pkg::ST_CLEAR) ? clr_q : set_w;
		tag_we    = (state_q == arsp_pkg::ST_ROW) && (op_q == arsp_pkg::OP_INSERT) && way_ok;
		gh_rway   = (state_q == arsp_pkg::ST_SH_RD) ? WAY_W'(idx_q + FILL_W'(1)) : idx_w;
		gh_wway   = idx_w;
		gh_wdata  = gh_rd;
		if (state_q == arsp_pkg::ST_PUSH) begin
			gh_wway  = (int'(n_q) >= WAYS) ? WAY_W'(WAYS - 1) : WAY_W'(n_q);
			gh_wdata = tag_q;
		end
		b1_we     = ((state_q == arsp_pkg::ST_SH_WR) || (state_q == arsp_pkg::ST_PUSH))
			&& !list_q;
		b2_we     = ((state_q == arsp_pkg::ST_SH_WR) || (state_q == arsp_pkg::ST_PUSH))
			&& list_q;
		div_start = state_q == arsp_pkg::ST_DIV;
		req.ready = state_q == arsp_pkg::ST_IDLE;
		out_load  = (state_q == arsp_pkg::ST_FIN) && (!out_valid_q || rsp.ready);
	end

	// Control registers: state, clearing pass, access counter, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= arsp_pkg::ST_CLEAR;
			clr_q       <= '0;
			now_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == arsp_pkg::ST_CLEAR) clr_q <= clr_q + SET_W'(1);
			if (accept) now_q <= now_q + STAMP_W'(1);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers stepped by the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			arsp_pkg::ST_IDLE: begin
				if (accept) begin
					op_q      <= arsp_pkg::opcode_t'(req.opcode);
					set_raw_q <= req.set_index;
					way_q     <= req.way_index;
					tag_q     <= TAG_BITS'(req.line_tag);
				end
			end
			arsp_pkg::ST_MOD: begin
				if (int'(set_raw_q) >= SETS)
					set_raw_q <= set_raw_q - arsp_pkg::SET_IN_W'(SETS);
			end
			arsp_pkg::ST_ROW: begin
				valid_r <= valid_ld;
				freq_r  <= freq_ld;
				stamp_r <= stamp_ld;
				f1_r    <= f1_rd;
				f2_r    <= f2_rd;
				p_r     <= p_rd;
				hit_q   <= arsp_pkg::GH_NONE;
				found_q <= 1'b0;
				best_q  <= '0;
				idx_q   <= '0;
				n1_q    <= '0;
				n2_q    <= '0;
				list_q  <= f1_rd == '0;
				n_q     <= (f1_rd != '0) ? f1_rd : f2_rd;
			end
			arsp_pkg::ST_GS_CMP: begin
				if (gs_match) begin
					hit_q <= list_q ? arsp_pkg::GH_B2 : arsp_pkg::GH_B1;
				end else if (idx_more) begin
					idx_q <= idx_q + FILL_W'(1);
				end else if (!list_q && f2_r != '0) begin
					list_q <= 1'b1;
					n_q    <= f2_r;
					idx_q  <= '0;
				end
			end
			arsp_pkg::ST_SH_WR: idx_q <= idx_q + FILL_W'(1);
			arsp_pkg::ST_PUPD: begin
				freq_r[way_w] <= 1'b1;
				if (list_q) begin
					p_r  <= (int'(p_r) > int'(delta)) ? p_r - P_W'(delta) : '0;
					f2_r <= f2_r - FILL_W'(1);
				end else begin
					p_r  <= (p_sum > p_cap) ? P_W'(p_cap) : P_W'(p_sum);
					f1_r <= f1_r - FILL_W'(1);
				end
			end
			arsp_pkg::ST_VCNT: begin
				if (valid_r[idx_w]) begin
					if (freq_r[idx_w]) n2_q <= n2_q + FILL_W'(1);
					else n1_q <= n1_q + FILL_W'(1);
				end
				idx_q    <= idx_last ? '0 : idx_q + FILL_W'(1);
				oldest_q <= now_q;
				have_q   <= 1'b0;
				fhave_q  <= 1'b0;
			end
			arsp_pkg::ST_VSCAN: begin
				if (scan_take) begin
					oldest_q <= stamp_r[idx_w];
					best_q   <= idx_w;
					have_q   <= 1'b1;
				end
				if (valid_r[idx_w] && !fhave_q) begin
					first_q <= idx_w;
					fhave_q <= 1'b1;
				end
				idx_q <= idx_q + FILL_W'(1);
			end
			arsp_pkg::ST_VSEL: begin
				if (!have_q && fhave_q) best_q <= first_q;
				found_q <= have_q || fhave_q;
			end
			arsp_pkg::ST_VTAG: begin
				tag_q  <= tag_rd;
				list_q <= freq_r[best_q];
				n_q    <= vfill;
				idx_q  <= '0;
			end
			arsp_pkg::ST_PUSH: begin
				if (list_q) f2_r <= (int'(n_q) >= WAYS) ? n_q : n_q + FILL_W'(1);
				else f1_r <= (int'(n_q) >= WAYS) ? n_q : n_q + FILL_W'(1);
			end
			arsp_pkg::ST_FIN: begin
				if (out_load) begin
					res_found_q <= found_q;
					res_way_q   <= arsp_pkg::VWAY_W'(best_q);
					res_ghit_q  <= hit_q;
					res_ts_q    <= arsp_pkg::TS_W'(p_r);
				end
			end
			default: ;
		endcase
	end

	// Row memories: cleared by the reset pass, written back when an item updates them.
	always_ff @(posedge clk) begin
		if (row_we) begin
			valid_mem[row_addr] <= (state_q == arsp_pkg::ST_CLEAR) ? '0 : valid_r;
			freq_mem[row_addr]  <= (state_q == arsp_pkg::ST_CLEAR) ? '0 : freq_r;
			stamp_mem[row_addr] <= (state_q == arsp_pkg::ST_CLEAR) ? '0 : stamp_r;
			f1_mem[row_addr]    <= (state_q == arsp_pkg::ST_CLEAR) ? '0 : f1_r;
			f2_mem[row_addr]    <= (state_q == arsp_pkg::ST_CLEAR) ? '0 : f2_r;
			p_mem[row_addr]     <= (state_q == arsp_pkg::ST_CLEAR) ? '0 : p_r;
		end
		valid_rd <= valid_mem[row_addr];
		freq_rd  <= freq_mem[row_addr];
		stamp_rd <= stamp_mem[row_addr];
		f1_rd    <= f1_mem[row_addr];
		f2_rd    <= f2_mem[row_addr];
		p_rd     <= p_mem[row_addr];
	end

	// Resident tag memory: written on insert, read at the chosen victim.
	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[line_addr(set_w, way_w)] <= tag_q;
		tag_rd <= tag_mem[line_addr(set_w, best_q)];
	end

	// Ghost tag memories, oldest entry at index zero.
	always_ff @(posedge clk) begin
		if (b1_we) b1_mem[line_addr(set_w, gh_wway)] <= gh_wdata;
		if (b2_we) b2_mem[line_addr(set_w, gh_wway)] <= gh_wdata;
		b1_rd <= b1_mem[line_addr(set_w, gh_rway)];
		b2_rd <= b2_mem[line_addr(set_w, gh_rway)];
	end

	// Ceiling divider for the target step.
	arsp_div #(
		.W(FILL_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.stat  (div_stat),
		.quot  (div_quot)
	);

	// Result channel.
	assign rsp.valid        = out_valid_q;
	assign rsp.victim_found = res_found_q;
	assign rsp.victim_way   = res_way_q;
	assign rsp.ghost_hit    = res_ghit_q;
	assign rsp.target_size  = res_ts_q;

	a_accept_mod: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == arsp_pkg::ST_MOD) else $error("accepted item not started");
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != arsp_pkg::ST_CLEAR |=> state_q != arsp_pkg::ST_CLEAR)
		else $error("clearing pass entered again");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == arsp_pkg::ST_IDLE)
		else $error("result not presented");
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == arsp_pkg::ST_WB |-> int'(f1_r) <= WAYS && int'(f2_r) <= WAYS)
		else $error("ghost fill above capacity");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == arsp_pkg::ST_DIV_WAIT)
		else $error("divider busy outside its wait state");

endmodule

// ----- tb/sv/adaptive_replacement_set_policy_test.sv -----
`timescale 1ns / 1ps
// Testbench of the adaptive replacement set policy: directed and random operation items,
// with a behavioral predictor of the per-set ARC state and an in-order result checker.
// Depends on arsp_pkg, arsp_if and the adaptive_replacement_set_policy top level.
module adaptive_replacement_set_policy_test;

	localparam int NSETS = 64;
	localparam int NWAYS = 8;

	typedef struct packed {
		logic       found;
		logic [2:0] vway;
		logic [1:0] ghit;
		logic [4:0] p;
	} arc_result_t;

	logic clk;
	logic arst_n;

	arsp_req_if req_ch();
	arsp_rsp_if rsp_ch();

	adaptive_replacement_set_policy u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Predictor state of the cache sets.
	logic        line_valid [NSETS][NWAYS];
	logic        line_freq  [NSETS][NWAYS];
	logic [31:0] line_tag   [NSETS][NWAYS];
	logic [31:0] line_stamp [NSETS][NWAYS];
	logic [31:0] b1_tags    [NSETS][$];
	logic [31:0] b2_tags    [NSETS][$];
	int          set_p      [NSETS];
	logic [31:0] op_count;

	arc_result_t pending_results[$];
	int          fail_count;
	bit          hold_off;
	int          sent_total;
	int          recv_total;

	// Clock.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Computes the ARC policy result of one operation and updates the state.
	function automatic arc_result_t arc_apply(arsp_pkg::opcode_t op, int s, int w,
		logic [31:0] tg);
		arc_result_t r;
		int n1;
		int n2;
		int best;
		int s1;
		int s2;
		int d;
		int idx;
		bit t1_side;
		bit have;
		logic [31:0] oldest;
		r = '0;
		op_count = op_count + 32'd1;
		if (op == arsp_pkg::OP_VICTIM) begin
			n1 = 0;
			n2 = 0;
			have = 0;
			best = 0;
			oldest = op_count;
			for (int i = 0; i < NWAYS; i++)
				if (line_valid[s][i]) begin
					if (line_freq[s][i]) n2++; else n1++;
				end
			t1_side = (n1 > set_p[s]) || (n2 == 0);
			for (int i = 0; i < NWAYS; i++)
				if (line_valid[s][i] && (line_freq[s][i] != t1_side)
					&& line_stamp[s][i] < oldest) begin
					oldest = line_stamp[s][i];
					best = i;
					have = 1;
				end
			if (!have)
				for (int i = 0; i < NWAYS; i++)
					if (!have && line_valid[s][i]) begin
						best = i;
						have = 1;
					end
			if (have) begin
				r.found = 1'b1;
				r.vway = best[2:0];
				if (line_freq[s][best]) begin
					if (b2_tags[s].size() >= NWAYS) b2_tags[s].delete(0);
					b2_tags[s].insert(b2_tags[s].size(), line_tag[s][best]);
				end else begin
					if (b1_tags[s].size() >= NWAYS) b1_tags[s].delete(0);
					b1_tags[s].insert(b1_tags[s].size(), line_tag[s][best]);
				end
			end
		end else if (op == arsp_pkg::OP_INSERT) begin
			s1 = b1_tags[s].size();
			s2 = b2_tags[s].size();
			line_stamp[s][w] = op_count;
			line_valid[s][w] = 1'b1;
			line_tag[s][w] = tg;
			idx = -1;
			for (int i = 0; i < s1; i++)
				if (idx < 0 && b1_tags[s][i] == tg) idx = i;
			if (idx >= 0) begin
				b1_tags[s].delete(idx);
				d = (s1 >= s2) ? 1 : (s2 + s1 - 1) / s1;
				set_p[s] = set_p[s] + d;
				if (set_p[s] > s1 + s2) set_p[s] = s1 + s2;
				line_freq[s][w] = 1'b1;
				r.ghit = arsp_pkg::GH_B1;
			end else begin
				for (int i = 0; i < s2; i++)
					if (idx < 0 && b2_tags[s][i] == tg) idx = i;
				if (idx >= 0) begin
					b2_tags[s].delete(idx);
					d = (s2 >= s1) ? 1 : (s1 + s2 - 1) / s2;
					set_p[s] = (set_p[s] > d) ? set_p[s] - d : 0;
					line_freq[s][w] = 1'b1;
					r.ghit = arsp_pkg::GH_B2;
				end else begin
					line_freq[s][w] = 1'b0;
				end
			end
		end else if (op == arsp_pkg::OP_TOUCH) begin
			line_stamp[s][w] = op_count;
			line_freq[s][w] = 1'b1;
		end else begin
			line_valid[s][w] = 1'b0;
		end
		r.p = set_p[s][4:0];
		return r;
	endfunction

	// Sends one item in the sender's burst pattern and predicts its result.
	// Valid stays high after the item so that the next one can follow directly.
	task automatic send_op(arsp_pkg::opcode_t op, int s, int w, logic [31:0] tg);
		if ($urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.set_index <= s[5:0];
		req_ch.way_index <= w[2:0];
		req_ch.line_tag <= tg;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_results.insert(pending_results.size(), arc_apply(op, s, w, tg));
		sent_total++;
		@(negedge clk);
	endtask

	// Ends a burst by dropping valid.
	task automatic end_burst();
		req_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		end_burst();
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// Extremes of every field and each special case in sets 0, 1 and 63.
	task automatic test_directed();
		send_op(arsp_pkg::OP_VICTIM, 0, 0, 32'h0);
		send_op(arsp_pkg::OP_TOUCH, 0, 5, 32'h0);
		send_op(arsp_pkg::OP_VICTIM, 0, 0, 32'h0);
		send_op(arsp_pkg::OP_INSERT, 63, 7, 32'hFFFF_FFFF);
		send_op(arsp_pkg::OP_INSERT, 63, 0, 32'h0000_0000);
		send_op(arsp_pkg::OP_VICTIM, 63, 0, 32'h0);
		send_op(arsp_pkg::OP_INSERT, 63, 0, 32'h0000_0000);
		send_op(arsp_pkg::OP_TOUCH, 63, 0, 32'h0);
		send_op(arsp_pkg::OP_VICTIM, 63, 0, 32'h0);
		send_op(arsp_pkg::OP_VICTIM, 63, 0, 32'h0);
		send_op(arsp_pkg::OP_INSERT, 63, 3, 32'h0000_0000);
		send_op(arsp_pkg::OP_INSERT, 63, 4, 32'hFFFF_FFFF);
		send_op(arsp_pkg::OP_INVAL, 63, 3, 32'h0);
		send_op(arsp_pkg::OP_INVAL, 63, 4, 32'h0);
		send_op(arsp_pkg::OP_VICTIM, 63, 0, 32'h0);
		send_op(arsp_pkg::OP_INSERT, 1, 2, 32'hA5A5_5A5A);
		send_op(arsp_pkg::OP_INVAL, 1, 2, 32'h0);
		send_op(arsp_pkg::OP_TOUCH, 1, 2, 32'h0);
		send_op(arsp_pkg::OP_INSERT, 1, 2, 32'h5A5A_A5A5);
		send_op(arsp_pkg::OP_VICTIM, 1, 0, 32'h0);
		wait_drained();
	endtask

	// Fills sets, evicts, and re-inserts evicted tags to drive the ghost lists.
	task automatic test_random_ghost(int rounds);
		int s;
		logic [31:0] pool [16];
		for (int r = 0; r < rounds; r++) begin
			s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
			for (int i = 0; i < 16; i++) pool[i] = (i < 12) ? 32'h100 + i : $urandom;
			for (int k = 0; k < 20; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: send_op(arsp_pkg::OP_INSERT, s, $urandom_range(0, 7),
						pool[$urandom_range(0, 15)]);
					4, 5: send_op(arsp_pkg::OP_TOUCH, s, $urandom_range(0, 7), $urandom);
					6: send_op(arsp_pkg::OP_INVAL, s, $urandom_range(0, 7), $urandom);
					default: send_op(arsp_pkg::OP_VICTIM, s, $urandom_range(0, 7), $urandom);
				endcase
			end
		end
	endtask

	// Long receiver stall while the sender keeps offering items.
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				for (int k = 0; k < 10; k++)
					send_op(arsp_pkg::opcode_t'($urandom_range(0, 3)), $urandom_range(0, 63),
						$urandom_range(0, 7), $urandom);
				end_burst();
			end
		join
		wait_drained();
	endtask

	// Receiver stall pattern.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= !hold_off && (recv_total % 64 < 32 || $urandom_range(0, 2) != 0);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		arc_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			recv_total++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result found=%0b way=%0d ghit=%0d p=%0d", $time,
					rsp_ch.victim_found, rsp_ch.victim_way, rsp_ch.ghost_hit,
					rsp_ch.target_size);
				fail_count++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (want != {rsp_ch.victim_found, rsp_ch.victim_way, rsp_ch.ghost_hit,
					rsp_ch.target_size}) begin
					$display("%0t: mismatch expected found=%0b way=%0d ghit=%0d p=%0d",
						$time, want.found, want.vway, want.ghit, want.p);
					$display("%0t:          actual   found=%0b way=%0d ghit=%0d p=%0d",
						$time, rsp_ch.victim_found, rsp_ch.victim_way, rsp_ch.ghost_hit,
						rsp_ch.target_size);
					fail_count++;
				end
			end
		end
	end

	// Overall time limit.
	initial begin
		#30ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		fail_count = 0;
		hold_off = 1'b0;
		sent_total = 0;
		recv_total = 0;
		op_count = '0;
		for (int s = 0; s < NSETS; s++) begin
			set_p[s] = 0;
			for (int w = 0; w < NWAYS; w++) begin
				line_valid[s][w] = 1'b0;
				line_freq[s][w] = 1'b0;
				line_stamp[s][w] = '0;
				line_tag[s][w] = '0;
			end
		end
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = arsp_pkg::OP_INSERT;
		req_ch.set_index = '0;
		req_ch.way_index = '0;
		req_ch.line_tag = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_ghost(38);
		test_backpressure();
		test_random_ghost(38);
		wait_drained();
		repeat (60) @(negedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/arsp_pkg.sv
rtl/arsp_if.sv
rtl/arsp_div.sv
rtl/adaptive_replacement_set_policy.sv
tb/sv/adaptive_replacement_set_policy_test.sv
